// ===== rtl/core/fbhs_pkg.sv =====
// fbhs_pkg: shared types, constants and hash helpers for the fingerprint block hash set
// used by the front, back and top level modules
package fbhs_pkg;
   localparam int Capacity = 256;
   localparam int NumBlocks = Capacity / 8;
   localparam int NumSlots = NumBlocks * 8;
   localparam int SlotW = $clog2(NumSlots);
   localparam int BlkW = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
   localparam int CurW = $clog2(NumSlots + 1);
   localparam int QDepth = 2;

   localparam logic [1:0] OP_ENSURE = 2'd0;
   localparam logic [1:0] OP_GET = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;
   localparam logic [1:0] OP_NEXT = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
   localparam logic [31:0] MM_C2 = 32'h1b873593;
   localparam logic [31:0] MM_C3 = 32'h85ebca6b;
   localparam logic [31:0] MM_C4 = 32'hc2b2ae35;
   localparam logic [31:0] MM_N = 32'he6546b64;

   typedef struct packed {
      logic [1:0] opcode;
      logic [63:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] slot_index;
      logic present;
      logic [63:0] key_out;
   } rsp_type;

   // classified work between front and back
   typedef struct packed {
      logic [1:0] opcode;
      logic [63:0] key;
      logic [3:0] tag;
      logic [BlkW-1:0] blk;
   } job_type;

   function automatic logic [31:0] rol32(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction
endpackage

// ===== rtl/core/fbhs_stream_if.sv =====
// fbhs_stream_if: valid/ready channel carrying one payload item
// depends on nothing; the payload type is chosen per instance
interface fbhs_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/core/fbhs_front.sv =====
// fbhs_front: accepts items and computes the murmur hash, tag and start block for ensure and get
// multi-cycle hash, at most one multiply per cycle; depends on fbhs_pkg
module fbhs_front (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input fbhs_pkg::req_type req_item,
   output logic job_valid,
   input logic job_ready,
   output fbhs_pkg::job_type job_item
);
   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_HASH = 4'b0010,
      F_OUT = 4'b0100,
      F_SPARE = 4'b1000
   } fstate_type;

   fstate_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [31:0] h_ff, h_in;
   fbhs_pkg::req_type req_ff, req_in;
   logic [31:0] hb;
   logic [31:0] base;

   always_comb begin
      hb = h_ff;
      case (step_ff)
         3'd0: hb = req_ff.key[31:0] * fbhs_pkg::MM_C1;
         3'd1: hb = fbhs_pkg::rol32(h_ff, 15) * fbhs_pkg::MM_C2;
         3'd2: hb = fbhs_pkg::rol32(h_ff, 13) * 32'd5 + fbhs_pkg::MM_N;
         3'd3: begin
            hb = h_ff ^ 32'd4;
            hb = (hb ^ (hb >> 16)) * fbhs_pkg::MM_C3;
         end
         3'd4: hb = (h_ff ^ (h_ff >> 13)) * fbhs_pkg::MM_C4;
         3'd5: hb = h_ff ^ (h_ff >> 16);
         default: hb = h_ff;
      endcase
   end

   assign base = {h_ff[31:4], 4'd0};

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      h_in = h_ff;
      req_in = req_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               req_in = req_item;
               step_in = 3'd0;
               state_in = (req_item.opcode == fbhs_pkg::OP_ENSURE ||
                           req_item.opcode == fbhs_pkg::OP_GET) ? F_HASH : F_OUT;
            end
         end
         F_HASH: begin
            h_in = hb;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) state_in = F_OUT;
         end
         F_OUT: if (job_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
      h_ff <= h_in;
      req_ff <= req_in;
   end

   assign req_ready = (state_ff == F_IDLE);
   assign job_valid = (state_ff == F_OUT);
   always_comb begin
      job_item.opcode = req_ff.opcode;
      job_item.key = req_ff.key;
      job_item.tag = h_ff[3:0] | 4'd1;
      job_item.blk = fbhs_pkg::BlkW'(((base % 32'(fbhs_pkg::Capacity)) >> 3)
                                     % 32'(fbhs_pkg::NumBlocks));
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !job_valid) else $error("ready while holding a job");
   a_hash_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_HASH && step_ff == 3'd5) |=> job_valid)
      else $error("hash did not finish");
   a_job_hold: assert property (@(posedge clock) disable iff (reset)
      (job_valid && !job_ready) |=> (job_valid && $stable(job_item)))
      else $error("job changed while stalled");
endmodule

// ===== rtl/core/fbhs_queue.sv =====
// fbhs_queue: short job queue between front and back
// depends on fbhs_pkg
module fbhs_queue (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input fbhs_pkg::job_type in_item,
   output logic out_valid,
   input logic out_ready,
   output fbhs_pkg::job_type out_item
);
   fbhs_pkg::job_type mem_ff [fbhs_pkg::QDepth];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'(fbhs_pkg::QDepth));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(fbhs_pkg::QDepth)) else $error("queue overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> (wp_ff == rp_ff))
      else $error("queue pointers disagree");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("queue count wrong");
endmodule

// ===== rtl/core/fbhs_back.sv =====
// fbhs_back: probes tag and key stores one slot at a time, inserts and iterates
// takes one job at a time; holds the stores and the result register; depends on fbhs_pkg
module fbhs_back (
   input logic clock,
   input logic reset,
   input logic job_valid,
   output logic job_ready,
   input fbhs_pkg::job_type job_item,
   output logic rsp_valid,
   input logic rsp_ready,
   output fbhs_pkg::rsp_type rsp_item
);
   localparam int SW = fbhs_pkg::SlotW;

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_READ = 5'b00010,
      B_CHECK = 5'b00100,
      B_DONE = 5'b01000,
      B_RSP = 5'b10000
   } bstate_type;

   bstate_type state_ff, state_in;
   logic [3:0] tag_ff [fbhs_pkg::NumSlots];
   logic [fbhs_pkg::NumSlots-1:0] valid_ff;
   logic [63:0] keys_ff [fbhs_pkg::NumSlots];
   fbhs_pkg::job_type job_ff;
   logic [SW-1:0] slot_ff, slot_in;
   logic [SW:0] cnt_ff, cnt_in;
   logic [fbhs_pkg::CurW-1:0] cur_ff, cur_in;
   logic [3:0] rtag_ff;
   logic [63:0] rkey_ff;
   logic rvalid_ff;
   fbhs_pkg::rsp_type rsp_ff, rsp_in;
   logic wr_en;
   logic [SW-1:0] wr_slot;
   logic last, is_next;

   assign is_next = (job_ff.opcode == fbhs_pkg::OP_NEXT);
   assign last = is_next ? (32'(slot_ff) == fbhs_pkg::NumSlots - 1)
                         : (32'(cnt_ff) == fbhs_pkg::NumSlots - 1);

   always_comb begin
      state_in = state_ff;
      slot_in = slot_ff;
      cnt_in = cnt_ff;
      cur_in = cur_ff;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_slot = slot_ff;
      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               rsp_in = '0;
               cnt_in = '0;
               case (job_item.opcode)
                  fbhs_pkg::OP_RESTART: begin
                     cur_in = '0;
                     state_in = B_RSP;
                  end
                  fbhs_pkg::OP_NEXT: begin
                     slot_in = cur_ff[SW-1:0];
                     if (32'(cur_ff) >= fbhs_pkg::NumSlots) begin
                        rsp_in.status = fbhs_pkg::ST_MISS;
                        state_in = B_RSP;
                     end else state_in = B_READ;
                  end
                  default: begin
                     slot_in = {job_item.blk, 3'd0};
                     state_in = B_READ;
                  end
               endcase
            end
         end
         B_READ: state_in = B_CHECK;
         B_CHECK: begin
            state_in = B_READ;
            case (job_ff.opcode)
               fbhs_pkg::OP_NEXT: begin
                  if (rvalid_ff) begin
                     rsp_in.slot_index = 8'(slot_ff);
                     rsp_in.present = 1'b1;
                     rsp_in.key_out = rkey_ff;
                     cur_in = fbhs_pkg::CurW'(slot_ff) + 1'b1;
                     state_in = B_RSP;
                  end else if (last) begin
                     rsp_in.status = fbhs_pkg::ST_MISS;
                     cur_in = fbhs_pkg::CurW'(fbhs_pkg::NumSlots);
                     state_in = B_RSP;
                  end
               end
               default: begin
                  if (job_ff.opcode == fbhs_pkg::OP_ENSURE && !rvalid_ff) begin
                     wr_en = 1'b1;
                     rsp_in.slot_index = 8'(slot_ff);
                     state_in = B_RSP;
                  end else if (rvalid_ff && rtag_ff == job_ff.tag &&
                               rkey_ff == job_ff.key) begin
                     rsp_in.slot_index = 8'(slot_ff);
                     rsp_in.present = 1'b1;
                     state_in = B_RSP;
                  end else if (last) begin
                     rsp_in.status = (job_ff.opcode == fbhs_pkg::OP_ENSURE) ?
                                     fbhs_pkg::ST_FULL : fbhs_pkg::ST_MISS;
                     state_in = B_RSP;
                  end
               end
            endcase
            if (state_in == B_READ) begin
               slot_in = slot_ff + 1'b1;
               if (!is_next && 32'(slot_ff) == fbhs_pkg::NumSlots - 1) slot_in = '0;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         B_RSP: if (rsp_ready) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         cur_ff <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         if (wr_en) valid_ff[wr_slot] <= 1'b1;
      end
      if (state_ff == B_IDLE && job_valid) job_ff <= job_item;
      slot_ff <= slot_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
      rvalid_ff <= valid_ff[slot_ff];
      rtag_ff <= tag_ff[slot_ff];
      rkey_ff <= keys_ff[slot_ff];
      if (wr_en) begin
         tag_ff[wr_slot] <= job_ff.tag;
         keys_ff[wr_slot] <= job_ff.key;
      end
   end

   assign job_ready = (state_ff == B_IDLE);
   assign rsp_valid = (state_ff == B_RSP);
   assign rsp_item = rsp_ff;

   a_ins: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_slot)]) else $error("insert lost");
   a_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != fbhs_pkg::ST_OK) |->
      (rsp_item.slot_index == 8'd0 && !rsp_item.present))
      else $error("failure with slot");
   a_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.key_out != 64'd0) |-> is_next)
      else $error("key_out outside next");
   a_cur: assert property (@(posedge clock) disable iff (reset)
      32'(cur_ff) <= fbhs_pkg::NumSlots) else $error("cursor past end");
endmodule

// ===== rtl/core/fingerprint_block_hash_set.sv =====
// fingerprint_block_hash_set: top level of the hash set, front, queue and back
// depends on fbhs_pkg, fbhs_stream_if, fbhs_front, fbhs_queue, fbhs_back
//
// channel | dir | payload
// req     | in  | opcode, key
// rsp     | out | status, slot_index, present, key_out
//
// the front hashes each ensure or get; restart and next skip the hash
// the back probes one slot at a time, read then check, from the start block until a hit,
// an empty slot (ensure only) or a full wrap; next scans slots from the cursor alike;
// restart zeroes the cursor; reset clears the slot valid bits at once, no clearing pass
// either side may stall; the queue holds two items
module fingerprint_block_hash_set (
   input logic clock,
   input logic reset,
   fbhs_stream_if.sink req,
   fbhs_stream_if.source rsp
);
   logic fq_valid, fq_ready, qb_valid, qb_ready;
   fbhs_pkg::job_type fq_item, qb_item;
   fbhs_pkg::req_type req_item;
   fbhs_pkg::rsp_type rsp_item;

   assign req_item = req.payload;
   assign rsp.payload = rsp_item;

   fbhs_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_item(req_item),
      .job_valid(fq_valid), .job_ready(fq_ready), .job_item(fq_item)
   );

   fbhs_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fq_valid), .in_ready(fq_ready), .in_item(fq_item),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_item(qb_item)
   );

   fbhs_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(qb_valid), .job_ready(qb_ready), .job_item(qb_item),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_item(rsp_item)
   );
endmodule
